[design/mtm_pkg.sv]
// ============================================================================
// mtm_pkg
// Shared types and constants for the multichannel temperature monitor.
// ============================================================================
package mtm_pkg;

    // Channel count and store geometry
    localparam int NUM_CHANNELS = 8;
    localparam int STORE_DEPTH  = 8;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int CH_W         = 3;
    localparam int ADC_W        = 8;
    localparam int TEMP_W       = 11;
    localparam int CNT_W        = 4;
    localparam int ALARM_W      = 3;
    localparam int SUM_W        = 14;   // holds 8 * -600
    localparam int ASUM_W       = SUM_W - 1;

    // Conversion: (adc*500 - 91800)/153, magnitude divided by reciprocal.
    // 153 * 109655 = 2^24 - 1, so ((n+1)*109655) >> 24 == n/153 (floored).
    localparam int ADC_GAIN     = 500;
    localparam int ADC_OFFSET   = 91800;
    localparam int NUM_W        = 19;
    localparam int MAG_W        = 17;
    localparam int CONV_RECIP   = 109655;
    localparam int CONV_SHIFT   = 24;
    localparam int CPROD_W      = 2 * MAG_W;

    // Average: |sum| * ceil(2^17/N) >> 17 gives |sum|/N for |sum| < 2^13
    localparam int AVG_SHIFT    = 17;
    localparam int AVG_RECIP_W  = AVG_SHIFT;
    localparam int AVG_RECIP    = ((1 << AVG_SHIFT) + NUM_CHANNELS - 1) / NUM_CHANNELS;
    localparam int APROD_W      = ASUM_W + AVG_RECIP_W;

    // Stream packing
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 56;

    // Alarm codes
    localparam logic [ALARM_W-1:0] ALARM_NONE      = 3'd0;
    localparam logic [ALARM_W-1:0] ALARM_ALL_COLD  = 3'd1;
    localparam logic [ALARM_W-1:0] ALARM_MOSTLY_COLD = 3'd2;
    localparam logic [ALARM_W-1:0] ALARM_SOME_COLD = 3'd3;
    localparam logic [ALARM_W-1:0] ALARM_ALTERNATE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STORE,
        ST_SCAN,
        ST_AVG,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic conv;
        logic store;
        logic scan_step;
        logic avg;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_range;
        logic is_last;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

[design/multichannel_temperature_monitor_core.sv]
// ============================================================================
// multichannel_temperature_monitor_core
// Eight-channel ADC temperature monitor with per-frame statistics and alarm.
// ============================================================================
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one ADC reading with its
//   channel number. Each reading is converted to a temperature and stored.
//   A reading on the last channel closes the frame: the store is walked and
//   one result (average, min, max, negative count, selected channel and the
//   alarm code) leaves on the output stream (m_tvalid/m_tready/m_tdata).
//   Other channels, and channel numbers beyond the channel count, give none.
//   cfg_we/cfg_wdata set the selected channel; write it only while idle.
// Timing:
//   One item at a time. An item on an ordinary channel passes capture, the
//   conversion multiply and the store write before the next s_tready. A
//   last-channel item then adds a walk of all eight store entries, the
//   averaging multiply and the result load.
// Reset and stall:
//   Reset clears the store to zero, the alarm to 0 and the selection to
//   channel 0. The result sits in an output register; the next item is
//   accepted while it waits, and only the next result load waits for it.
// ============================================================================
module multichannel_temperature_monitor_core
    import mtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,    // channel[2:0], adc_sample[10:3]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,    // average[10:0], minimum[21:11],
                                              // maximum[32:22], negative_count[36:33],
                                              // selected_temp[47:37], alarm_state[50:48]
    input  logic                  cfg_we,
    input  logic [CH_W-1:0]       cfg_wdata
);

    ctrl_cmd_t                cmd;
    ctrl_sts_t                sts;
    logic signed [TEMP_W-1:0] average;
    logic signed [TEMP_W-1:0] minimum;
    logic signed [TEMP_W-1:0] maximum;
    logic [CNT_W-1:0]         negative_count;
    logic signed [TEMP_W-1:0] selected_temp;
    logic [ALARM_W-1:0]       alarm_state;

    // Sequencer
    mtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    mtm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_channel     (s_tdata[CH_W-1:0]),
        .in_adc_sample  (s_tdata[CH_W+ADC_W-1:CH_W]),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .average        (average),
        .minimum        (minimum),
        .maximum        (maximum),
        .negative_count (negative_count),
        .selected_temp  (selected_temp),
        .alarm_state    (alarm_state)
    );

    // Output packing, zero filled to whole bytes
    assign m_tdata = {5'b0, alarm_state, selected_temp, negative_count,
                      maximum, minimum, average};

endmodule

[design/mtm_ctrl.sv]
// ============================================================================
// mtm_ctrl
// Sequencer: input capture, conversion, store write, scan, average, emit.
// ============================================================================
module mtm_ctrl
    import mtm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                state_next = sts.in_range ? ST_STORE : ST_IDLE;
            end
            ST_STORE:
            begin
                state_next = sts.is_last ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_AVG:
            begin
                cmd.avg = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A result is only produced from a sample on the last channel
    a_scan_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_STORE) |-> $past(sts.is_last))
        else $error("scan started for a channel other than the last");

    // The emit stage is left only by loading the output register
    a_emit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |-> cmd.emit)
        else $error("emit stage left without a result");

endmodule

[design/mtm_datapath.sv]
// ============================================================================
// mtm_datapath
// Conversion, channel store, scan statistics, average, alarm and output reg.
// ============================================================================
module mtm_datapath
    import mtm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output ctrl_sts_t                 sts,
    input  logic [CH_W-1:0]           in_channel,
    input  logic [ADC_W-1:0]          in_adc_sample,
    input  logic                      cfg_we,
    input  logic [CH_W-1:0]           cfg_wdata,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [TEMP_W-1:0]  average,
    output logic signed [TEMP_W-1:0]  minimum,
    output logic signed [TEMP_W-1:0]  maximum,
    output logic [CNT_W-1:0]          negative_count,
    output logic signed [TEMP_W-1:0]  selected_temp,
    output logic [ALARM_W-1:0]        alarm_state
);

    logic [CH_W-1:0]            sel_ch_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [ADC_W-1:0]           adc_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       numneg_reg;
    logic signed [TEMP_W-1:0]   temps_reg [STORE_DEPTH];
    logic [IDX_W-1:0]           idx_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [TEMP_W-1:0]   min_reg;
    logic signed [TEMP_W-1:0]   max_reg;
    logic [CNT_W-1:0]           neg_reg;
    logic                       alt_reg;
    logic signed [TEMP_W-1:0]   sel_reg;
    logic signed [TEMP_W-1:0]   avg_reg;
    logic [ALARM_W-1:0]         alarm_reg;
    logic [ALARM_W-1:0]         alarm_next;
    logic                       out_valid_reg;
    logic signed [TEMP_W-1:0]   o_avg_reg;
    logic signed [TEMP_W-1:0]   o_min_reg;
    logic signed [TEMP_W-1:0]   o_max_reg;
    logic [CNT_W-1:0]           o_neg_reg;
    logic signed [TEMP_W-1:0]   o_sel_reg;

    logic signed [NUM_W-1:0]    num;
    logic [NUM_W-1:0]           num_abs;
    logic [CPROD_W-1:0]         conv_prod;
    logic signed [TEMP_W-1:0]   conv_mag;
    logic signed [TEMP_W-1:0]   temp_new;
    logic signed [TEMP_W-1:0]   t_cur;
    logic                       in_stat;
    logic                       first;
    logic                       t_neg;
    logic                       t_pos;
    logic [ASUM_W-1:0]          sum_abs;
    logic [APROD_W-1:0]         avg_prod;
    logic signed [TEMP_W-1:0]   avg_mag;
    logic                       avg_neg;
    logic                       avg_pos;
    logic                       max_neg;
    logic                       max_pos;

    // Status to the sequencer
    assign sts.in_range  = ({1'b0, ch_reg} < (CH_W + 1)'(NUM_CHANNELS));
    assign sts.is_last   = (ch_reg == CH_W'(NUM_CHANNELS - 1));
    assign sts.scan_last = (idx_reg == IDX_W'(STORE_DEPTH - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Selected channel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_ch_reg <= '0;
        end
        else if (cfg_we)
        begin
            sel_ch_reg <= cfg_wdata;
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ch_reg  <= in_channel;
            adc_reg <= in_adc_sample;
        end
    end

    // Numerator and its magnitude (plus one for the reciprocal trick)
    assign num     = NUM_W'(signed'({1'b0, adc_reg}) * ADC_GAIN) - NUM_W'(ADC_OFFSET);
    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    always_ff @(posedge clk)
    begin
        if (cmd.conv)
        begin
            mag_reg    <= MAG_W'(num_abs) + MAG_W'(1);
            numneg_reg <= num[NUM_W-1];
        end
    end

    // Divide by 153 through the reciprocal, then restore the sign
    assign conv_prod = CPROD_W'(mag_reg) * CPROD_W'(CONV_RECIP);
    assign conv_mag  = TEMP_W'(conv_prod[CPROD_W-1:CONV_SHIFT]);
    assign temp_new  = numneg_reg ? -conv_mag : conv_mag;

    // Channel store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_DEPTH; k++)
            begin
                temps_reg[k] <= '0;
            end
        end
        else if (cmd.store)
        begin
            temps_reg[ch_reg[IDX_W-1:0]] <= temp_new;
        end
    end

    // Scan: one entry a cycle
    assign t_cur   = temps_reg[idx_reg];
    assign in_stat = ({1'b0, idx_reg} < (IDX_W + 1)'(NUM_CHANNELS));
    assign first   = (idx_reg == '0);
    assign t_neg   = t_cur[TEMP_W-1];
    assign t_pos   = !t_cur[TEMP_W-1] && (t_cur != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.store)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            sum_reg <= (first ? '0 : sum_reg) + (in_stat ? SUM_W'(t_cur) : '0);
            if (first || (in_stat && t_cur < min_reg))
            begin
                min_reg <= t_cur;
            end
            if (first || (in_stat && t_cur > max_reg))
            begin
                max_reg <= t_cur;
            end
            neg_reg <= (first ? '0 : neg_reg) + CNT_W'(in_stat && t_neg);
            alt_reg <= (first ? 1'b1 : alt_reg)
                       && !(in_stat && (idx_reg[0] ? !t_pos : !t_neg));
            if (idx_reg == sel_ch_reg[IDX_W-1:0])
            begin
                sel_reg <= t_cur;
            end
        end
    end

    // Average: |sum|/N by reciprocal, truncated toward zero
    assign sum_abs  = sum_reg[SUM_W-1] ? ASUM_W'(-sum_reg) : ASUM_W'(sum_reg);
    assign avg_prod = APROD_W'(sum_abs) * APROD_W'(AVG_RECIP);
    assign avg_mag  = TEMP_W'(avg_prod[APROD_W-1:AVG_SHIFT]);

    always_ff @(posedge clk)
    begin
        if (cmd.avg)
        begin
            avg_reg <= sum_reg[SUM_W-1] ? -avg_mag : avg_mag;
        end
    end

    // Alarm rules in priority order
    assign avg_neg = avg_reg[TEMP_W-1];
    assign avg_pos = !avg_reg[TEMP_W-1] && (avg_reg != '0);
    assign max_neg = max_reg[TEMP_W-1];
    assign max_pos = !max_reg[TEMP_W-1] && (max_reg != '0);

    always_comb
    begin
        alarm_next = alarm_reg;
        if (avg_neg && max_neg)
        begin
            alarm_next = ALARM_ALL_COLD;
        end
        else if (avg_neg && max_pos)
        begin
            alarm_next = ALARM_MOSTLY_COLD;
        end
        else if (avg_pos && neg_reg >= CNT_W'(2))
        begin
            alarm_next = ALARM_SOME_COLD;
        end
        else if (alt_reg)
        begin
            alarm_next = ALARM_ALTERNATE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg <= ALARM_NONE;
        end
        else if (cmd.emit)
        begin
            alarm_reg <= alarm_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_avg_reg <= avg_reg;
            o_min_reg <= min_reg;
            o_max_reg <= max_reg;
            o_neg_reg <= neg_reg;
            o_sel_reg <= sel_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign average        = o_avg_reg;
    assign minimum        = o_min_reg;
    assign maximum        = o_max_reg;
    assign negative_count = o_neg_reg;
    assign selected_temp  = o_sel_reg;
    assign alarm_state    = alarm_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    // Alarm code stays within its defined set
    a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg <= ALARM_ALTERNATE)
        else $error("alarm code out of range");

    // The alarm changes only when a result is produced
    a_alarm_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.emit) |-> $stable(alarm_reg))
        else $error("alarm changed outside a result");

    // Minimum never exceeds maximum in a delivered result
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_min_reg <= o_max_reg && o_neg_reg <= CNT_W'(NUM_CHANNELS)))
        else $error("inconsistent statistics in result");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the multichannel temperature monitor core.
// A queue of pending samples feeds a falling-edge driver with random gaps.
// A rising-edge monitor mirrors the store, the alarm register and the
// selected channel, and compares each frame result field by field.
// The stimulus starts with directed frames, then moves on to random phases,
// each phase opened by a write of the selected channel while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mtm_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 1000;  // cycles with no item moving on either side
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 116;

    // conversion (adc*500 - 91800)/153
    localparam int CONV_MUL      = 500;
    localparam int CONV_SUB      = 91800;
    localparam int CONV_DIV      = 153;

    typedef struct packed {
        logic [ADC_W-1:0] adc;
        logic [CH_W-1:0]  channel;
    } sample_t;

    typedef struct {
        logic signed [TEMP_W-1:0] average;
        logic signed [TEMP_W-1:0] minimum;
        logic signed [TEMP_W-1:0] maximum;
        logic        [CNT_W-1:0]  negative_count;
        logic signed [TEMP_W-1:0] selected_temp;
        logic        [ALARM_W-1:0] alarm_state;
    } frame_stats_t;

    typedef enum int {
        FRAME_UNIFORM,
        FRAME_ALTERNATE,
        FRAME_EXTREME,
        FRAME_PARTIAL,
        FRAME_NOISE
    } frame_kind_e;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic [CH_W-1:0]     cfg_wdata = '0;

    // mirror of the block state
    int                  temps [STORE_DEPTH] = '{default: 0};
    logic [ALARM_W-1:0]  alarm_model = ALARM_NONE;
    logic [CH_W-1:0]     select_model = '0;

    sample_t             pending [$];
    frame_stats_t        stats_due [$];
    int                  queued_count = 0;
    int                  mismatches   = 0;
    int                  quiet_cycles = 0;
    int                  send_gap     = 0;
    int                  stall_left   = 0;
    logic                in_taken     = 1'b0;
    logic                calm         = 1'b0;

    multichannel_temperature_monitor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Store one sample; on the last channel work out the frame statistics
    task automatic take_sample(input logic [S_DATA_W-1:0] word);
        int           ch;
        int           adc;
        int           sum;
        int           mn;
        int           mx;
        int           neg;
        int           avg;
        bit           alternating;
        frame_stats_t s;
        ch  = int'(word[2:0]);
        adc = int'(word[10:3]);
        if (ch >= NUM_CHANNELS)
            return;
        temps[ch] = (adc * CONV_MUL - CONV_SUB) / CONV_DIV;   // truncates toward zero
        if (ch != NUM_CHANNELS - 1)
            return;
        sum = 0;
        mn  = temps[0];
        mx  = temps[0];
        neg = 0;
        alternating = 1'b1;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            sum += temps[k];
            if (temps[k] < mn) mn = temps[k];
            if (temps[k] > mx) mx = temps[k];
            if (temps[k] < 0) neg++;
            if ((k % 2) == 0)
            begin
                if (!(temps[k] < 0)) alternating = 1'b0;
            end
            else
            begin
                if (!(temps[k] > 0)) alternating = 1'b0;
            end
        end
        avg = sum / NUM_CHANNELS;
        // first matching rule wins; otherwise the alarm holds
        if (avg < 0 && mx < 0)
            alarm_model = ALARM_ALL_COLD;
        else if (avg < 0 && mx > 0)
            alarm_model = ALARM_MOSTLY_COLD;
        else if (avg > 0 && neg >= 2)
            alarm_model = ALARM_SOME_COLD;
        else if (alternating)
            alarm_model = ALARM_ALTERNATE;
        s.average        = avg[TEMP_W-1:0];
        s.minimum        = mn[TEMP_W-1:0];
        s.maximum        = mx[TEMP_W-1:0];
        s.negative_count = neg[CNT_W-1:0];
        s.selected_temp  = temps[select_model][TEMP_W-1:0];
        s.alarm_state    = alarm_model;
        stats_due.push_back(s);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_sample(input int ch, input int adc);
        sample_t it;
        it.channel = ch[CH_W-1:0];
        it.adc     = adc[ADC_W-1:0];
        pending.push_back(it);
        queued_count++;
    endtask

    task automatic queue_frame(input frame_kind_e kind);
        int n;
        case (kind)
            FRAME_UNIFORM:
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                    queue_sample(ch, $urandom_range(0, 255));
            // entries straddle zero so the average often truncates to 0
            FRAME_ALTERNATE:
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                    queue_sample(ch, (ch % 2 == 0) ? $urandom_range(176, 183)
                                                   : $urandom_range(184, 191));
            FRAME_EXTREME:
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                begin
                    case ($urandom_range(0, 4))
                        0:       queue_sample(ch, 0);
                        1:       queue_sample(ch, 255);
                        2:       queue_sample(ch, 183);
                        3:       queue_sample(ch, 184);
                        default: queue_sample(ch, $urandom_range(0, 255));
                    endcase
                end
            // refresh a few entries only, then close the frame
            FRAME_PARTIAL:
            begin
                for (int ch = 0; ch < NUM_CHANNELS - 1; ch++)
                    if ($urandom_range(0, 2) == 0)
                        queue_sample(ch, $urandom_range(0, 255));
                queue_sample(NUM_CHANNELS - 1, $urandom_range(0, 255));
            end
            default:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    queue_sample($urandom_range(0, 7), $urandom_range(0, 255));
            end
        endcase
    endtask

    // Wait until every item is sent and every result is back, then let the
    // block finish any ordinary item still in flight
    task automatic wait_drained;
        do
            @(posedge clk);
        while (pending.size() != 0 || s_tvalid || stats_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_select(input logic [CH_W-1:0] value);
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Sender: present pending items, with random idle bursts
    always @(negedge clk)
    begin
        sample_t             nxt;
        logic                v;
        logic [S_DATA_W-1:0] d;
        if (rst_n)
        begin
            v = s_tvalid;
            d = s_tdata;
            if (!s_tvalid || in_taken)
            begin
                v = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0)
                begin
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(0, 5);
                    else
                    begin
                        nxt     = pending.pop_front();
                        v       = 1'b1;
                        d       = '0;
                        d[2:0]  = nxt.channel;
                        d[10:3] = nxt.adc;
                    end
                end
            end
            s_tvalid <= v;
            s_tdata  <= d;
        end
    end

    // Receiver: ready with random stall bursts
    always @(negedge clk)
    begin
        logic r;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                r = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                r = 1'b0;
            end
            else
                r = 1'b1;
            m_tready <= r;
        end
    end

    // Monitor: check results, track register writes, predict accepted items
    always @(posedge clk)
    begin
        frame_stats_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    compare_field("average", want.average, $signed(m_tdata[10:0]));
                    compare_field("minimum", want.minimum, $signed(m_tdata[21:11]));
                    compare_field("maximum", want.maximum, $signed(m_tdata[32:22]));
                    compare_field("negative_count", want.negative_count, m_tdata[36:33]);
                    compare_field("selected_temp", want.selected_temp,
                                  $signed(m_tdata[47:37]));
                    compare_field("alarm_state", want.alarm_state, m_tdata[50:48]);
                end
            end
            if (cfg_we)
                select_model = cfg_wdata;
            if (s_tvalid && s_tready)
                take_sample(s_tdata);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int              phase;
        int              roll;
        logic [CH_W-1:0] sel;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // last channel alone: rest of the store still holds its reset zeros,
        // no rule holds and the alarm stays at none
        queue_sample(7, 0);
        // every entry at the bottom of the range: all cold
        for (int ch = 0; ch < 7; ch++)
            queue_sample(ch, 0);
        queue_sample(7, 0);
        wait_drained;
        write_select(7);
        // odd entries at the top: cold average with a warm maximum
        queue_sample(1, 255);
        queue_sample(3, 255);
        queue_sample(5, 255);
        queue_sample(7, 255);
        // two cold entries left under a warm average
        queue_sample(4, 255);
        queue_sample(6, 255);
        queue_sample(7, 255);
        wait_drained;
        write_select(0);
        // alternating signs just around zero, average truncates to zero
        for (int ch = 0; ch < 8; ch++)
            queue_sample(ch, (ch % 2 == 0) ? 183 : 184);

        // random phases, each opened by a register write while idle
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained;
            calm = (phase == 3) || (phase == NUM_PHASES - 1);
            case (phase)
                0:       sel = 3'd7;
                1:       sel = 3'd0;
                default: sel = $urandom_range(0, 7);
            endcase
            write_select(sel);
            queued_count = 0;
            while (queued_count < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 9);
                case (roll)
                    0, 1, 2: queue_frame(FRAME_UNIFORM);
                    3, 4:    queue_frame(FRAME_ALTERNATE);
                    5, 6:    queue_frame(FRAME_EXTREME);
                    7, 8:    queue_frame(FRAME_PARTIAL);
                    default: queue_frame(FRAME_NOISE);
                endcase
            end
        end

        wait_drained;
        if (mismatches == 0 && stats_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
design/mtm_pkg.sv
design/mtm_ctrl.sv
design/mtm_datapath.sv
design/multichannel_temperature_monitor_core.sv
test/tb.sv
